>>> sv/tkr_pkg.sv
// Shared types and codes for the top-k ranking list and its cells.
`default_nettype none

package tkr_pkg;

    // Ordering codes held in the rank_mode register.
    localparam logic [1:0] MODE_FAST_TIME = 2'd0;
    localparam logic [1:0] MODE_SLOW_TIME = 2'd1;
    localparam logic [1:0] MODE_TOTAL     = 2'd2;
    localparam logic [1:0] MODE_DISTINCT  = 2'd3;

    // Request codes.
    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_RANK_MODE   = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    // One ranked record.
    typedef struct packed {
        logic [63:0] num;
        logic [31:0] tim;
        logic [5:0]  tot;
        logic [3:0]  dis;
    } t_rec;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic scan_start;
        logic step;
        logic commit;
        logic keep;
        logic grow;
        logic rd_load;
        logic rd_shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> sv/tkr_cell.sv
// One cell of the ranking row: a stored record, its scan token and its read stage.
`default_nettype none

module tkr_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tkr_pkg::t_cell_ctl i_ctl,
    input  wire logic [1:0]        i_mode,
    input  wire logic [CW-1:0]     i_held,
    input  wire tkr_pkg::t_rec     i_new,
    input  wire logic              i_tok_in,
    input  wire logic              i_prev_mv,
    input  wire tkr_pkg::t_rec     i_prev_rec,
    input  wire tkr_pkg::t_rec     i_bus_in,
    output logic                   o_tok_pass,
    output logic                   o_hit,
    output logic                   o_mv,
    output tkr_pkg::t_rec          o_rec,
    output tkr_pkg::t_rec          o_bus
);
    import tkr_pkg::*;

    logic r_tok;
    logic r_mv;
    t_rec r_slot;
    t_rec r_bus;
    logic w_beat;
    logic w_is_p;
    logic w_take_new;
    logic w_shift;

    // The offered record strictly outranks the stored one.
    always_comb begin
        case (i_mode)
            MODE_FAST_TIME: w_beat = i_new.tim < r_slot.tim;
            MODE_SLOW_TIME: w_beat = i_new.tim > r_slot.tim;
            MODE_TOTAL: w_beat = (i_new.tot > r_slot.tot) ||
                                 ((i_new.tot == r_slot.tot) && (i_new.dis > r_slot.dis));
            MODE_DISTINCT: w_beat = (i_new.dis > r_slot.dis) ||
                                    ((i_new.dis == r_slot.dis) && (i_new.tot > r_slot.tot));
            default: w_beat = 1'b0;
        endcase
    end

    // The insertion point is the highest-ranked cell marked to move, or the first
    // empty cell when nothing moves.
    assign w_is_p     = (r_mv || (i_held == CW'(IDX))) && !i_prev_mv;
    assign w_take_new = i_ctl.keep && w_is_p;
    assign w_shift    = i_prev_mv && ((CW'(IDX) < i_held) || i_ctl.grow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_mv  <= 1'b0;
        end else if (i_ctl.scan_start) begin
            r_tok <= (i_held == CW'(IDX + 1));
            r_mv  <= 1'b0;
        end else if (i_ctl.step) begin
            r_tok <= i_tok_in;
            r_mv  <= r_mv | (r_tok & w_beat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            if (w_take_new) begin
                r_slot <= i_new;
            end else if (w_shift) begin
                r_slot <= i_prev_rec;
            end
        end
        if (i_ctl.rd_load) begin
            r_bus <= r_slot;
        end else if (i_ctl.rd_shift) begin
            r_bus <= i_bus_in;
        end
    end

    assign o_tok_pass = r_tok & w_beat;
    assign o_hit      = r_tok & ~w_beat;
    assign o_mv       = r_mv;
    assign o_rec      = r_slot;
    assign o_bus      = r_bus;

endmodule

`default_nettype wire

>>> sv/top_k_ranking_list.sv
// Top level of the top-k ranking list: sequencer, registers and the row of cells.
`default_nettype none

// The block keeps the best records seen so far, sorted from best to worst, in a
// row of CAPACITY cells, cell 0 holding the best. A request is one transaction on
// the command channel: it is taken at a rising edge where start is high and busy
// is low. An offer sends a scan token up the row from the worst held entry, one
// cell per cycle, marking every entry the record outranks; where the token stops,
// the marked cells each move down by one at the same clock edge and the record
// drops into the gap. A read loads every cell's record into its read stage and
// shifts the row towards cell 0, one cell per cycle, until the entry of rank r
// reaches cell 0; a read of an empty rank does not shift. In both cases the result
// is on the output ports, with o_valid high for a single cycle, the first in which
// busy is low, and a new request may be taken in that same cycle. The walk along
// the row therefore sets the rate: no new request is taken while busy is high.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// Reset empties the list and sets fastest-time ordering with sixteen entries;
// stored records themselves are not cleared, as no empty rank is ever read.
// Configuration goes through the APB port; the user must write it only while
// the block is idle, which the block itself does not enforce. Lowering
// max_entries drops the worst entries at once.

module top_k_ranking_list #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command channel.
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [3:0]  i_read_rank,
    input  wire logic [63:0] i_number_value,
    input  wire logic [31:0] i_calc_time,
    input  wire logic [5:0]  i_total_factors,
    input  wire logic [3:0]  i_distinct_factors,
    // Result channel.
    output logic             o_valid,
    output logic             o_kept,
    output logic [3:0]       o_placed_rank,
    output logic             o_entry_valid,
    output logic [63:0]      o_entry_number,
    output logic [31:0]      o_entry_time,
    output logic [5:0]       o_entry_total,
    output logic [3:0]       o_entry_distinct,
    output logic [4:0]       o_fill_count,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tkr_pkg::*;

    // Width of a count of held entries, and a width wide enough to compare it
    // against the five-bit register field and the four-bit read-rank field.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } t_state;

    t_state        r_state;
    logic [1:0]    r_mode;
    logic [4:0]    r_max;
    logic [CW-1:0] r_held;
    logic [CW-1:0] r_pos;
    logic          r_rd_ok;
    t_rec          r_rec;

    logic          r_valid;
    logic          r_kept;
    logic [3:0]    r_placed;
    logic          r_entry_valid;
    t_rec          r_entry;
    logic [4:0]    r_fill;

    t_cell_ctl     w_ctl;
    logic          w_accept;
    logic          w_cfg_wr;
    logic [CW-1:0] w_lim;
    logic [CW-1:0] w_new_lim;
    logic          w_grow;
    logic          w_keep;
    logic          w_hit_any;
    logic          w_finish;
    logic          w_rd_in_range;
    logic [CW-1:0] w_held_next;

    logic [CAPACITY-1:0] w_tok_pass;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_mv;
    t_rec                w_cell_rec [CAPACITY];
    t_rec                w_cell_bus [CAPACITY];

    // A limit of zero acts as one, and anything above the row length as the
    // row length.
    function automatic logic [CW-1:0] f_limit(input logic [4:0] v);
        logic [WW-1:0] m;
        logic [CW-1:0] res;
        m = WW'(v);
        if (m == '0) begin
            res = CW'(1);
        end else if (m > WW'(CAPACITY)) begin
            res = CW'(CAPACITY);
        end else begin
            res = CW'(m);
        end
        return res;
    endfunction

    assign w_lim     = f_limit(r_max);
    assign w_new_lim = f_limit(pwdata[4:0]);

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_cfg_wr = psel && penable && pwrite;
    assign busy     = (r_state != ST_IDLE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_ENTRIES) ? {27'd0, r_max} : {30'd0, r_mode};

    // The scan ends when the token sits on an entry the record does not outrank,
    // or when it has passed the best entry.
    assign w_hit_any   = |w_hit;
    assign w_finish    = (r_pos == '0) || w_hit_any;
    assign w_grow      = (r_held < w_lim);
    assign w_keep      = (r_pos < r_held) || w_grow;
    assign w_held_next = w_grow ? (r_held + CW'(1)) : r_held;

    assign w_rd_in_range = (WW'(i_read_rank) < WW'(r_held));

    always_comb begin
        w_ctl            = '0;
        w_ctl.scan_start = w_accept && (i_req_type == REQ_OFFER);
        w_ctl.rd_load    = w_accept && (i_req_type == REQ_READ);
        w_ctl.step       = (r_state == ST_SCAN) && !w_finish;
        w_ctl.commit     = (r_state == ST_SCAN) && w_finish;
        w_ctl.keep       = w_keep;
        w_ctl.grow       = w_grow;
        w_ctl.rd_shift   = (r_state == ST_READ) && (r_pos != '0);
    end

    // The row of cells: the token walks towards cell 0, records move away from it
    // on insertion, and the read stages shift towards it.
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic w_tok_in;
        logic w_prev_mv;
        t_rec w_prev_rec;
        t_rec w_bus_in;

        if (j == CAPACITY - 1) begin : g_last
            assign w_tok_in = 1'b0;
            assign w_bus_in = '0;
        end else begin : g_inner
            assign w_tok_in = w_tok_pass[j+1];
            assign w_bus_in = w_cell_bus[j+1];
        end

        if (j == 0) begin : g_first
            assign w_prev_mv  = 1'b0;
            assign w_prev_rec = '0;
        end else begin : g_rest
            assign w_prev_mv  = w_mv[j-1];
            assign w_prev_rec = w_cell_rec[j-1];
        end

        tkr_cell #(
            .CW  (CW),
            .IDX (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_mode     (r_mode),
            .i_held     (r_held),
            .i_new      (r_rec),
            .i_tok_in   (w_tok_in),
            .i_prev_mv  (w_prev_mv),
            .i_prev_rec (w_prev_rec),
            .i_bus_in   (w_bus_in),
            .o_tok_pass (w_tok_pass[j]),
            .o_hit      (w_hit[j]),
            .o_mv       (w_mv[j]),
            .o_rec      (w_cell_rec[j]),
            .o_bus      (w_cell_bus[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_FAST_TIME;
            r_max   <= 5'd16;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            // The user must write configuration only while idle; this block does not enforce it.
            if (w_cfg_wr) begin
                if (paddr[2] == REG_RANK_MODE) begin
                    r_mode <= pwdata[1:0];
                end else begin
                    r_max <= pwdata[4:0];
                    if (r_held > w_new_lim) begin
                        r_held <= w_new_lim;
                    end
                end
            end

            case (r_state)
                ST_IDLE: begin
                    r_valid <= 1'b0;
                    if (w_accept) begin
                        if (i_req_type == REQ_OFFER) begin
                            r_rec.num <= i_number_value;
                            r_rec.tim <= i_calc_time;
                            r_rec.tot <= i_total_factors;
                            r_rec.dis <= i_distinct_factors;
                            r_pos     <= r_held;
                            r_state   <= ST_SCAN;
                        end else begin
                            r_rd_ok <= w_rd_in_range;
                            r_pos   <= w_rd_in_range ? CW'(i_read_rank) : '0;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_finish) begin
                        r_held        <= w_held_next;
                        r_valid       <= 1'b1;
                        r_kept        <= w_keep;
                        r_placed      <= w_keep ? 4'(WW'(r_pos)) : 4'd0;
                        r_entry_valid <= 1'b0;
                        r_entry       <= '0;
                        r_fill        <= 5'(WW'(w_held_next));
                        r_state       <= ST_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_pos   <= r_pos - CW'(1);
                    end
                end
                ST_READ: begin
                    if (r_pos == '0) begin
                        r_valid       <= 1'b1;
                        r_kept        <= 1'b0;
                        r_placed      <= 4'd0;
                        r_entry_valid <= r_rd_ok;
                        r_entry       <= r_rd_ok ? w_cell_bus[0] : '0;
                        r_fill        <= 5'(WW'(r_held));
                        r_state       <= ST_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_pos   <= r_pos - CW'(1);
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_kept           = r_kept;
    assign o_placed_rank    = r_placed;
    assign o_entry_valid    = r_entry_valid;
    assign o_entry_number   = r_entry.num;
    assign o_entry_time     = r_entry.tim;
    assign o_entry_total    = r_entry.tot;
    assign o_entry_distinct = r_entry.dis;
    assign o_fill_count     = r_fill;

endmodule

`default_nettype wire
